// ===== rtl/box_circle_contact_macros.svh =====
// Assertion macros used by the back end of the box-circle contact RTL.
`ifndef BOX_CIRCLE_CONTACT_MACROS_SVH
`define BOX_CIRCLE_CONTACT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define BCC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define BCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bcc_pkg.sv =====
// Shared constants, codes and types of the box-circle contact block.
package bcc_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COORD_BITS = 32;
    localparam int CFG_W      = 30;
    localparam int OFF_W      = 31;
    localparam int RAD_W      = 30;
    localparam int NRM_W      = FRAC_BITS + 2;
    localparam int PEN_W      = COORD_BITS - 1;
    localparam int CRD_W      = COORD_BITS;
    localparam int SQ_W       = 2 * COORD_BITS;
    localparam int SQ_STAGES  = COORD_BITS;
    localparam int QUO_W      = FRAC_BITS + 1;
    localparam int DIV_W      = CRD_W + FRAC_BITS;
    localparam int PROD_W     = QUO_W + PEN_W;

    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;
    localparam int ODEPTH     = 4;
    localparam int OPTR_W     = 2;

    localparam logic signed [NRM_W-1:0] ONE_FX = NRM_W'(1) << FRAC_BITS;

    localparam logic [1:0] KIND_X_EDGE = 2'd0;
    localparam logic [1:0] KIND_Y_EDGE = 2'd1;
    localparam logic [1:0] KIND_CORNER = 2'd2;

    localparam logic CFG_HALF_WIDTH  = 1'b0;
    localparam logic CFG_HALF_HEIGHT = 1'b1;

    // Classified item as the front hands it to the back.
    typedef struct packed {
        logic                    is_edge;
        logic [1:0]              kind;
        logic                    neg;
        logic [PEN_W-1:0]        aux;   // edge: penetration, corner: radius
        logic signed [CRD_W-1:0] px;    // edge: point, corner: offset
        logic signed [CRD_W-1:0] py;
    } job_t;

    // Per-slot sideband carried down the back pipeline.
    typedef struct packed {
        logic                    is_edge;
        logic [1:0]              kind;
        logic                    neg;
        logic                    item_end;
        logic [PEN_W-1:0]        aux;
        logic signed [CRD_W-1:0] dx;
        logic signed [CRD_W-1:0] dy;
    } side_t;

    typedef struct packed {
        logic [1:0]              kind;
        logic signed [NRM_W-1:0] nx;
        logic signed [NRM_W-1:0] ny;
        logic [PEN_W-1:0]        pen;
        logic signed [CRD_W-1:0] px;
        logic signed [CRD_W-1:0] py;
        logic                    last;
    } res_t;

endpackage

// ===== rtl/bcc_front.sv =====
// Front: configuration registers, edge classification and job build.
module bcc_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [bcc_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [bcc_pkg::OFF_W-1:0]  offset_x,
    input  logic signed [bcc_pkg::OFF_W-1:0]  offset_y,
    input  logic [bcc_pkg::RAD_W-1:0]         radius,
    input  logic                              q_full,
    output logic                              push,
    output bcc_pkg::job_t                     push_job,
    output logic [bcc_pkg::CFG_W-1:0]         half_w,
    output logic [bcc_pkg::CFG_W-1:0]         half_h
);
    import bcc_pkg::*;

    logic [CFG_W-1:0]        hw_reg, hh_reg;
    logic signed [CRD_W-1:0] ox, oy, ax, ay, sepx, sepy, rs, hws, hhs;
    logic signed [CRD_W-1:0] pen_x, pen_y, hx, hy;
    logic                    x_edge, y_edge;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_reg <= '0;
            hh_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HALF_WIDTH:  hw_reg <= cfg_data;
                CFG_HALF_HEIGHT: hh_reg <= cfg_data;
                default:         hw_reg <= hw_reg;
            endcase
        end
    end

    assign half_w = hw_reg;
    assign half_h = hh_reg;

    always_comb
    begin
        ox   = CRD_W'(offset_x);
        oy   = CRD_W'(offset_y);
        ax   = ox[CRD_W-1] ? -ox : ox;
        ay   = oy[CRD_W-1] ? -oy : oy;
        hws  = $signed({2'b00, hw_reg});
        hhs  = $signed({2'b00, hh_reg});
        rs   = $signed({2'b00, radius});
        sepx = ax - hws;
        sepy = ay - hhs;
        x_edge = (sepx <= rs) && (sepy <= 0);
        y_edge = (sepx <= 0) && (sepy <= rs);
        pen_x = rs - sepx;
        pen_y = rs - sepy;
        hx    = pen_x >>> 1;
        hy    = pen_y >>> 1;

        push_job.is_edge = 1'b0;
        push_job.kind    = KIND_CORNER;
        push_job.neg     = 1'b0;
        push_job.aux     = {1'b0, radius};
        push_job.px      = ox;
        push_job.py      = oy;
        if (x_edge)
        begin
            push_job.is_edge = 1'b1;
            push_job.kind    = KIND_X_EDGE;
            push_job.neg     = ox[CRD_W-1];
            push_job.aux     = pen_x[PEN_W-1:0];
            push_job.px      = ox[CRD_W-1] ? ox + hx : ox - hx;
        end
        else if (y_edge)
        begin
            push_job.is_edge = 1'b1;
            push_job.kind    = KIND_Y_EDGE;
            push_job.neg     = oy[CRD_W-1];
            push_job.aux     = pen_y[PEN_W-1:0];
            push_job.py      = oy[CRD_W-1] ? oy + hy : oy - hy;
        end
    end

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

endmodule

// ===== rtl/bcc_queue.sv =====
// Short job queue between front and back.
module bcc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bcc_pkg::job_t push_job,
    input  logic          pop,
    output logic          head_valid,
    output bcc_pkg::job_t head_job,
    output logic          full
);
    import bcc_pkg::*;

    job_t              q_reg [QDEPTH];
    logic [QPTR_W-1:0] wp_reg, rp_reg;
    logic [QPTR_W:0]   cnt_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
        end
    end

    assign head_valid = (cnt_reg != '0);
    assign head_job   = q_reg[rp_reg];
    assign full       = (cnt_reg == (QPTR_W+1)'(QDEPTH));

endmodule

// ===== rtl/bcc_back.sv =====
// Back: corner sequencer, square root and divide pipelines, result collector.
`include "box_circle_contact_macros.svh"

module bcc_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      head_valid,
    input  bcc_pkg::job_t             head_job,
    output logic                      pop,
    input  logic [bcc_pkg::CFG_W-1:0] half_w,
    input  logic [bcc_pkg::CFG_W-1:0] half_h,
    output logic                      out_valid,
    input  logic                      out_stall,
    output bcc_pkg::res_t             out_word
);
    import bcc_pkg::*;

    logic        adv, issue;
    logic [1:0]  k_reg;

    // issue and square stages
    logic        s0_v_reg, s1_v_reg;
    side_t       s0_side_reg, s1_side_reg, s0_side;
    logic [2*OFF_W-1:0] ax2_reg, ay2_reg;
    logic signed [CRD_W-1:0] hws, hhs, cx, cy;
    logic [OFF_W-1:0] adx0, ady0;

    // square root pipeline
    logic        rt_v_reg    [SQ_STAGES+1];
    side_t       rt_side_reg [SQ_STAGES+1];
    logic [SQ_W-1:0] rt_x_reg [SQ_STAGES+1];
    logic [SQ_W-1:0] rt_r_reg [SQ_STAGES+1];

    // divide pipeline
    logic        dv_v_reg    [QUO_W+1];
    side_t       dv_side_reg [QUO_W+1];
    logic        dv_c_reg    [QUO_W+1];
    logic [CRD_W-1:0] dv_den_reg [QUO_W+1];
    logic [DIV_W-1:0] dv_rx_reg  [QUO_W+1];
    logic [DIV_W-1:0] dv_ry_reg  [QUO_W+1];
    logic [QUO_W-1:0] dv_qx_reg  [QUO_W+1];
    logic [QUO_W-1:0] dv_qy_reg  [QUO_W+1];
    logic [CRD_W-1:0] dist0;
    logic [OFF_W-1:0] adx1, ady1;

    // multiply stage
    logic        mu_v_reg, mu_c_reg;
    side_t       mu_side_reg;
    logic [PROD_W-1:0] mu_px_reg, mu_py_reg;
    logic [QUO_W-1:0]  mu_qx_reg, mu_qy_reg;
    logic [PEN_W-1:0]  mu_pen_reg;
    logic [CRD_W-1:0]  pen_m, m_m;

    // collector and output queue
    res_t        cur, pa, pb, pend_reg, pend_next;
    logic        pend_v_reg, pend_v_next, fire;
    logic [1:0]  npush;
    logic [CRD_W-1:0] magx, magy;
    res_t        of_reg [ODEPTH];
    logic [OPTR_W-1:0] owp_reg, orp_reg;
    logic [OPTR_W:0]   ocnt_reg;
    logic        opop;

    assign adv   = (ocnt_reg <= (OPTR_W+1)'(ODEPTH - 2));
    assign issue = adv && head_valid;
    assign pop   = issue && (head_job.is_edge || k_reg == 2'd3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            k_reg <= 2'd0;
        else if (issue && !head_job.is_edge)
            k_reg <= k_reg + 2'd1;
    end

    // corners in order (+,+), (+,-), (-,-), (-,+)
    always_comb
    begin
        hws = $signed({2'b00, half_w});
        hhs = $signed({2'b00, half_h});
        cx  = k_reg[1] ? -hws : hws;
        cy  = (k_reg == 2'd0 || k_reg == 2'd3) ? hhs : -hhs;
        s0_side.is_edge  = head_job.is_edge;
        s0_side.kind     = head_job.kind;
        s0_side.neg      = head_job.neg;
        s0_side.item_end = head_job.is_edge || (k_reg == 2'd3);
        s0_side.aux      = head_job.aux;
        s0_side.dx       = head_job.is_edge ? head_job.px : head_job.px - cx;
        s0_side.dy       = head_job.is_edge ? head_job.py : head_job.py - cy;
    end

    always_comb
    begin
        adx0 = s0_side_reg.dx[CRD_W-1] ? OFF_W'(-s0_side_reg.dx) : OFF_W'(s0_side_reg.dx);
        ady0 = s0_side_reg.dy[CRD_W-1] ? OFF_W'(-s0_side_reg.dy) : OFF_W'(s0_side_reg.dy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg    <= 1'b0;
            s1_v_reg    <= 1'b0;
            rt_v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            s0_v_reg    <= head_valid;
            s1_v_reg    <= s0_v_reg;
            rt_v_reg[0] <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_side_reg    <= s0_side;
            s1_side_reg    <= s0_side_reg;
            ax2_reg        <= adx0 * adx0;
            ay2_reg        <= ady0 * ady0;
            rt_side_reg[0] <= s1_side_reg;
            rt_x_reg[0]    <= SQ_W'(ax2_reg) + SQ_W'(ay2_reg);
            rt_r_reg[0]    <= '0;
        end
    end

    // one root bit per stage, highest first
    for (genvar j = 0; j < SQ_STAGES; j++)
    begin : g_sqrt
        localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << (2 * (SQ_STAGES - 1 - j));
        logic            take;
        logic [SQ_W-1:0] trial;

        assign trial = rt_r_reg[j] + BITV;
        assign take  = (rt_x_reg[j] >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rt_v_reg[j+1] <= 1'b0;
            else if (adv)
                rt_v_reg[j+1] <= rt_v_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rt_side_reg[j+1] <= rt_side_reg[j];
                rt_x_reg[j+1]    <= take ? rt_x_reg[j] - trial : rt_x_reg[j];
                rt_r_reg[j+1]    <= take ? (rt_r_reg[j] >> 1) + BITV : rt_r_reg[j] >> 1;
            end
        end
    end

    always_comb
    begin
        dist0 = rt_r_reg[SQ_STAGES][CRD_W-1:0];
        adx1  = rt_side_reg[SQ_STAGES].dx[CRD_W-1] ? OFF_W'(-rt_side_reg[SQ_STAGES].dx)
                                                   : OFF_W'(rt_side_reg[SQ_STAGES].dx);
        ady1  = rt_side_reg[SQ_STAGES].dy[CRD_W-1] ? OFF_W'(-rt_side_reg[SQ_STAGES].dy)
                                                   : OFF_W'(rt_side_reg[SQ_STAGES].dy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_v_reg[0] <= 1'b0;
        else if (adv)
            dv_v_reg[0] <= rt_v_reg[SQ_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_side_reg[0] <= rt_side_reg[SQ_STAGES];
            dv_c_reg[0]    <= (dist0 != '0)
                              && (dist0 <= CRD_W'(rt_side_reg[SQ_STAGES].aux));
            dv_den_reg[0]  <= dist0;
            dv_rx_reg[0]   <= DIV_W'(adx1) << FRAC_BITS;
            dv_ry_reg[0]   <= DIV_W'(ady1) << FRAC_BITS;
            dv_qx_reg[0]   <= '0;
            dv_qy_reg[0]   <= '0;
        end
    end

    // restoring divide, one quotient bit per stage
    for (genvar j = 0; j < QUO_W; j++)
    begin : g_div
        localparam int SH = QUO_W - 1 - j;
        logic [DIV_W-1:0] dsh;
        logic             tx, ty;

        assign dsh = DIV_W'(dv_den_reg[j]) << SH;
        assign tx  = (dv_rx_reg[j] >= dsh);
        assign ty  = (dv_ry_reg[j] >= dsh);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_v_reg[j+1] <= 1'b0;
            else if (adv)
                dv_v_reg[j+1] <= dv_v_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_side_reg[j+1] <= dv_side_reg[j];
                dv_c_reg[j+1]    <= dv_c_reg[j];
                dv_den_reg[j+1]  <= dv_den_reg[j];
                dv_rx_reg[j+1]   <= tx ? dv_rx_reg[j] - dsh : dv_rx_reg[j];
                dv_ry_reg[j+1]   <= ty ? dv_ry_reg[j] - dsh : dv_ry_reg[j];
                dv_qx_reg[j+1]   <= dv_qx_reg[j] | (QUO_W'(tx) << SH);
                dv_qy_reg[j+1]   <= dv_qy_reg[j] | (QUO_W'(ty) << SH);
            end
        end
    end

    always_comb
    begin
        pen_m = CRD_W'(dv_side_reg[QUO_W].aux) - dv_den_reg[QUO_W];
        m_m   = CRD_W'(dv_side_reg[QUO_W].aux) - (pen_m >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mu_v_reg <= 1'b0;
        else if (adv)
            mu_v_reg <= dv_v_reg[QUO_W];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mu_side_reg <= dv_side_reg[QUO_W];
            mu_c_reg    <= dv_c_reg[QUO_W];
            mu_qx_reg   <= dv_qx_reg[QUO_W];
            mu_qy_reg   <= dv_qy_reg[QUO_W];
            mu_pen_reg  <= pen_m[PEN_W-1:0];
            mu_px_reg   <= dv_qx_reg[QUO_W] * m_m[PEN_W-1:0];
            mu_py_reg   <= dv_qy_reg[QUO_W] * m_m[PEN_W-1:0];
        end
    end

    // build the word at the tail
    always_comb
    begin
        magx = CRD_W'(mu_px_reg >> FRAC_BITS);
        magy = CRD_W'(mu_py_reg >> FRAC_BITS);
        cur.last = 1'b0;
        cur.kind = mu_side_reg.kind;
        if (mu_side_reg.is_edge)
        begin
            cur.nx  = (mu_side_reg.kind == KIND_X_EDGE)
                      ? (mu_side_reg.neg ? -ONE_FX : ONE_FX) : '0;
            cur.ny  = (mu_side_reg.kind == KIND_Y_EDGE)
                      ? (mu_side_reg.neg ? -ONE_FX : ONE_FX) : '0;
            cur.pen = mu_side_reg.aux;
            cur.px  = mu_side_reg.dx;
            cur.py  = mu_side_reg.dy;
        end
        else
        begin
            cur.nx  = mu_side_reg.dx[CRD_W-1] ? -$signed({1'b0, mu_qx_reg})
                                              : $signed({1'b0, mu_qx_reg});
            cur.ny  = mu_side_reg.dy[CRD_W-1] ? -$signed({1'b0, mu_qy_reg})
                                              : $signed({1'b0, mu_qy_reg});
            cur.pen = mu_pen_reg;
            cur.px  = mu_side_reg.dx[CRD_W-1] ? -$signed(magx) : $signed(magx);
            cur.py  = mu_side_reg.dy[CRD_W-1] ? -$signed(magy) : $signed(magy);
        end
    end

    assign fire = adv && mu_v_reg;

    // hold one corner word back until the next one shows whether it is last
    always_comb
    begin
        npush       = 2'd0;
        pa          = pend_reg;
        pb          = cur;
        pend_next   = pend_reg;
        pend_v_next = pend_v_reg;
        if (fire)
        begin
            if (mu_side_reg.is_edge)
            begin
                npush   = 2'd1;
                pa      = cur;
                pa.last = 1'b1;
            end
            else if (mu_c_reg)
            begin
                if (mu_side_reg.item_end)
                begin
                    pend_v_next = 1'b0;
                    if (pend_v_reg)
                    begin
                        npush   = 2'd2;
                        pa.last = 1'b0;
                        pb.last = 1'b1;
                    end
                    else
                    begin
                        npush   = 2'd1;
                        pa      = cur;
                        pa.last = 1'b1;
                    end
                end
                else
                begin
                    if (pend_v_reg)
                    begin
                        npush   = 2'd1;
                        pa.last = 1'b0;
                    end
                    pend_next   = cur;
                    pend_v_next = 1'b1;
                end
            end
            else if (mu_side_reg.item_end && pend_v_reg)
            begin
                npush       = 2'd1;
                pa.last     = 1'b1;
                pend_v_next = 1'b0;
            end
        end
    end

    assign opop = (ocnt_reg != '0) && !out_stall;

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (npush != 2'd0)
            of_reg[owp_reg] <= pa;
        if (npush == 2'd2)
            of_reg[owp_reg + 1'b1] <= pb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_v_reg <= 1'b0;
            owp_reg    <= '0;
            orp_reg    <= '0;
            ocnt_reg   <= '0;
        end
        else
        begin
            pend_v_reg <= pend_v_next;
            owp_reg    <= owp_reg + OPTR_W'(npush);
            if (opop)
                orp_reg <= orp_reg + 1'b1;
            ocnt_reg   <= ocnt_reg + (OPTR_W+1)'(npush) - (OPTR_W+1)'(opop);
        end
    end

    assign out_valid = (ocnt_reg != '0);
    assign out_word  = of_reg[orp_reg];

    `BCC_ASSERT_IMPL(a_k_on_corner, k_reg != 2'd0, head_valid && !head_job.is_edge, "corner sequence lost its job")
    `BCC_ASSERT_IMPL(a_edge_no_pend, fire && mu_side_reg.is_edge, !pend_v_reg, "held corner word across item end")
    `BCC_ASSERT_IMPL(a_ocnt_max, 1'b1, ocnt_reg <= (OPTR_W+1)'(ODEPTH), "output queue overflow")

endmodule

// ===== rtl/box_circle_contact.sv =====
// Box-circle contact: an edge item makes one pass and a corner item four, one per corner;
// while the output queue has room, one corner per cycle enters the 32-stage square root
// and 17-stage divide pipelines.
// Results leave one per cycle from a four-entry output queue while out_stall is low.
// Reset (rst_n low, asynchronous) clears half extents to zero and empties all queues.
module box_circle_contact (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [bcc_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [bcc_pkg::OFF_W-1:0]  offset_x,
    input  logic signed [bcc_pkg::OFF_W-1:0]  offset_y,
    input  logic [bcc_pkg::RAD_W-1:0]         radius,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        contact_kind,
    output logic signed [bcc_pkg::NRM_W-1:0]  normal_x,
    output logic signed [bcc_pkg::NRM_W-1:0]  normal_y,
    output logic [bcc_pkg::PEN_W-1:0]         penetration,
    output logic signed [bcc_pkg::CRD_W-1:0]  point_x,
    output logic signed [bcc_pkg::CRD_W-1:0]  point_y,
    output logic                              last
);
    import bcc_pkg::*;

    logic             push, q_full, q_pop, head_valid;
    job_t             push_job, head_job;
    logic [CFG_W-1:0] half_w, half_h;
    res_t             out_word;

    bcc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .offset_x  (offset_x),
        .offset_y  (offset_y),
        .radius    (radius),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job),
        .half_w    (half_w),
        .half_h    (half_h)
    );

    bcc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_job   (head_job),
        .full       (q_full)
    );

    bcc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (q_pop),
        .half_w     (half_w),
        .half_h     (half_h),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_word)
    );

    assign contact_kind = out_word.kind;
    assign normal_x     = out_word.nx;
    assign normal_y     = out_word.ny;
    assign penetration  = out_word.pen;
    assign point_x      = out_word.px;
    assign point_y      = out_word.py;
    assign last         = out_word.last;

endmodule

// ===== bench/contact_checker.sv =====
// Checker for the box-circle contact block: predicts every contact and compares the results.
module contact_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [bcc_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic signed [bcc_pkg::OFF_W-1:0]  offset_x,
    input  logic signed [bcc_pkg::OFF_W-1:0]  offset_y,
    input  logic [bcc_pkg::RAD_W-1:0]         radius,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [1:0]                        contact_kind,
    input  logic signed [bcc_pkg::NRM_W-1:0]  normal_x,
    input  logic signed [bcc_pkg::NRM_W-1:0]  normal_y,
    input  logic [bcc_pkg::PEN_W-1:0]         penetration,
    input  logic signed [bcc_pkg::CRD_W-1:0]  point_x,
    input  logic signed [bcc_pkg::CRD_W-1:0]  point_y,
    input  logic                              last,
    output int                                errors,
    output int                                pending
);
    import bcc_pkg::*;

    localparam longint ONE      = longint'(1) << FRAC_BITS;
    localparam longint PT_HIGH  = (longint'(1) << (COORD_BITS - 1)) - 1;
    localparam longint PT_LOW   = -PT_HIGH - 1;

    longint box_hw;
    longint box_hh;
    res_t   expected_contacts[$];

    assign pending = expected_contacts.size();

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned acc;
        longint unsigned b;
        acc = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= acc + b)
            begin
                v = v - (acc + b);
                acc = (acc >> 1) + b;
            end
            else
                acc = acc >> 1;
            b = b >> 2;
        end
        return acc;
    endfunction

    function automatic void add_contact(logic [1:0] kind, longint nx, longint ny, longint pen,
                                        longint px, longint py, logic fin);
        res_t c;
        c.kind = kind;
        c.nx   = nx[NRM_W-1:0];
        c.ny   = ny[NRM_W-1:0];
        c.pen  = PEN_W'(clamp(pen, 0, PT_HIGH));
        c.px   = CRD_W'(clamp(px, PT_LOW, PT_HIGH));
        c.py   = CRD_W'(clamp(py, PT_LOW, PT_HIGH));
        c.last = fin;
        expected_contacts.push_back(c);
    endfunction

    function automatic void predict_contacts(longint ox, longint oy, longint r);
        longint sx, sy, sepx, sepy, pen, h, cx, cy, dx, dy, reach, m, nx, ny;
        longint unsigned ax, ay;
        int found;
        found = 0;
        sx = ox < 0 ? -ONE : ONE;
        sy = oy < 0 ? -ONE : ONE;
        sepx = (ox < 0 ? -ox : ox) - box_hw;
        sepy = (oy < 0 ? -oy : oy) - box_hh;
        if (sepx <= r && sepy <= 0)
        begin
            pen = r - sepx;
            h = pen >>> 1;
            add_contact(KIND_X_EDGE, sx, 0, pen, ox - (ox < 0 ? -h : h), oy, 1'b1);
            return;
        end
        if (sepx <= 0 && sepy <= r)
        begin
            pen = r - sepy;
            h = pen >>> 1;
            add_contact(KIND_Y_EDGE, 0, sy, pen, ox, oy - (oy < 0 ? -h : h), 1'b1);
            return;
        end
        // corners in order (+,+), (+,-), (-,-), (-,+)
        for (int k = 0; k < 4; k++)
        begin
            cx = (k < 2) ? box_hw : -box_hw;
            cy = (k == 0 || k == 3) ? box_hh : -box_hh;
            dx = ox - cx;
            dy = oy - cy;
            ax = dx < 0 ? -dx : dx;
            ay = dy < 0 ? -dy : dy;
            reach = longint'(root_floor(ax * ax + ay * ay));
            if (reach > 0 && reach <= r)
            begin
                pen = r - reach;
                m = r - (pen >>> 1);
                nx = (dx * ONE) / reach;
                ny = (dy * ONE) / reach;
                add_contact(KIND_CORNER, nx, ny, pen, (nx * m) / ONE, (ny * m) / ONE, 1'b0);
                found++;
            end
        end
        if (found > 0) expected_contacts[$].last = 1'b1;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    initial errors = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_hw <= 0;
            box_hh <= 0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_HALF_WIDTH) box_hw <= longint'(cfg_data);
            else box_hh <= longint'(cfg_data);
        end
    end

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && in_valid && !in_stall)
            predict_contacts(longint'(offset_x), longint'(offset_y), longint'(radius));
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_contacts.size() == 0)
                report_mismatch("unexpected word, kind", contact_kind, -1);
            else
            begin
                want = expected_contacts.pop_front();
                if (contact_kind !== want.kind) report_mismatch("kind", contact_kind, want.kind);
                if (normal_x !== want.nx) report_mismatch("normal_x", normal_x, want.nx);
                if (normal_y !== want.ny) report_mismatch("normal_y", normal_y, want.ny);
                if (penetration !== want.pen)
                    report_mismatch("penetration", penetration, want.pen);
                if (point_x !== want.px) report_mismatch("point_x", point_x, want.px);
                if (point_y !== want.py) report_mismatch("point_y", point_y, want.py);
                if (last !== want.last) report_mismatch("last", last, want.last);
            end
        end
    end

endmodule

// ===== bench/tb_top.sv =====
// Top of the box-circle contact testbench: clock, reset, stimulus and verdict.
module tb_top;
    import bcc_pkg::*;

    localparam longint OFF_HIGH = (longint'(1) << (OFF_W - 1)) - 1;
    localparam longint OFF_LOW  = -(longint'(1) << (OFF_W - 1));
    localparam longint CFG_MAX  = (longint'(1) << CFG_W) - 1;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic                     cfg_index;
    logic [CFG_W-1:0]         cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [OFF_W-1:0]  offset_x;
    logic signed [OFF_W-1:0]  offset_y;
    logic [RAD_W-1:0]         radius;
    logic                     out_valid;
    logic                     out_stall;
    logic [1:0]               contact_kind;
    logic signed [NRM_W-1:0]  normal_x;
    logic signed [NRM_W-1:0]  normal_y;
    logic [PEN_W-1:0]         penetration;
    logic signed [CRD_W-1:0]  point_x;
    logic signed [CRD_W-1:0]  point_y;
    logic                     last;
    int                       errors;
    int                       pending;
    bit                       calm;
    longint                   cur_hw;
    longint                   cur_hh;

    box_circle_contact dut (.*);

    contact_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // receiver stalls in random bursts until the quiet tail of the run
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_word(longint ox, longint oy, longint r);
        offset_x <= ox[OFF_W-1:0];
        offset_y <= oy[OFF_W-1:0];
        radius   <= r[RAD_W-1:0];
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // drain, let in-flight corner items settle, then write both extents
    task automatic set_box(longint hw, longint hh);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_HALF_WIDTH;
        cfg_data  <= hw[CFG_W-1:0];
        @(posedge clk);
        cfg_index <= CFG_HALF_HEIGHT;
        cfg_data  <= hh[CFG_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_hw = hw;
        cur_hh = hh;
    endtask

    function automatic longint jitter(longint center, longint spread);
        longint v;
        if (spread > (longint'(1) << 29)) spread = longint'(1) << 29;
        if (spread < 1) spread = 1;
        v = center + longint'($urandom_range(0, 2 * spread)) - spread;
        return v < OFF_LOW ? OFF_LOW : (v > OFF_HIGH ? OFF_HIGH : v);
    endfunction

    task automatic random_word();
        longint r, ox, oy, span;
        int pick;
        pick = $urandom_range(0, 9);
        r = ($urandom_range(0, 7) == 0) ? longint'($urandom_range(0, CFG_MAX))
                                        : longint'($urandom_range(0, 1 << 19));
        span = r + r / 2 + 1;
        if (pick == 0)
        begin
            // noise: any bit pattern
            ox = $signed($urandom);
            oy = $signed($urandom);
            r  = $urandom;
        end
        else if (pick <= 3)
        begin
            ox = jitter($urandom_range(0, 1) ? cur_hw : -cur_hw, span);
            oy = jitter($urandom_range(0, 1) ? cur_hh : -cur_hh, span);
        end
        else if (pick <= 5)
        begin
            ox = jitter($urandom_range(0, 1) ? cur_hw : -cur_hw, span);
            oy = jitter(0, cur_hh);
        end
        else if (pick <= 7)
        begin
            ox = jitter(0, cur_hw);
            oy = jitter($urandom_range(0, 1) ? cur_hh : -cur_hh, span);
        end
        else
        begin
            ox = jitter(0, cur_hw + span);
            oy = jitter(0, cur_hh + span);
        end
        send_word(ox, oy, r);
    endtask

    initial
    begin
        longint boxes[5][2];
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_HALF_WIDTH;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        offset_x  <= '0;
        offset_y  <= '0;
        radius    <= '0;
        calm      = 1'b0;
        cur_hw    = 0;
        cur_hh    = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // point box after reset: zero offset counts as positive
        send_word(0, 0, 0);
        send_word(OFF_HIGH, OFF_LOW, CFG_MAX);
        send_word(OFF_LOW, OFF_HIGH, 0);
        send_word(-5, 0, 5);
        send_word(0, -7, 3);
        send_word(3, 4, 5);
        send_word(-3, -4, 4);

        set_box(1 << 16, 1 << 16);
        send_word(1 << 16, 0, 0);
        send_word(-(3 << 16) / 2, 100, 1 << 16);
        send_word(0, (3 << 16) / 2, 1 << 16);
        send_word(200, -(3 << 16) / 2, 1 << 16);
        send_word((1 << 16) + 300, (1 << 16) + 400, 1000);
        send_word(-(1 << 16) - 300, (1 << 16) + 400, 499);
        send_word(1 << 16, 1 << 16, 1 << 16);
        send_word(5 << 16, 5 << 16, 1 << 16);
        send_word(OFF_HIGH, OFF_HIGH, CFG_MAX);
        send_word(0, 0, CFG_MAX);

        // tiny box: all four corners in reach of the first two words
        set_box(1, 1);
        send_word(2, 2, 100);
        send_word(-2, 3, 1000);
        send_word(0, 2, 0);

        boxes = '{'{3 << 16, 3 << 15}, '{1, 2}, '{CFG_MAX, CFG_MAX}, '{0, CFG_MAX},
                  '{CFG_MAX, 0}};
        for (int p = 0; p < 6; p++)
        begin
            if (p < 5) set_box(boxes[p][0], boxes[p][1]);
            else set_box($urandom_range(0, 1 << 22), $urandom_range(0, 1 << 22));
            for (int i = 0; i < 73; i++)
            begin
                if (p == 5 && i >= 33) calm = 1'b1;
                random_word();
            end
        end
        in_valid <= 1'b0;

        calm = 1'b1;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== box_circle_contact.f =====
+incdir+rtl
rtl/bcc_pkg.sv
rtl/bcc_front.sv
rtl/bcc_queue.sv
rtl/bcc_back.sv
rtl/box_circle_contact.sv
bench/contact_checker.sv
bench/tb_top.sv
